[hdl/rwc_pkg.sv]
`timescale 1ns / 1ps

package rwc_pkg;

    // Window and frame limits.
    localparam int MAX_RADIUS     = 2;
    localparam int MAX_WIDTH      = 1024;
    localparam int MAX_HEIGHT     = 1024;
    localparam int COEF_FRAC_BITS = 14;

    localparam int KSIDE  = 2 * MAX_RADIUS + 1;
    localparam int KTAPS  = KSIDE * KSIDE;
    localparam int LINES  = 3 * MAX_RADIUS + 1;

    // Field and counter widths.
    localparam int RAD_W   = 2;
    localparam int SIZE_W  = 11;
    localparam int COL_W   = $clog2(MAX_WIDTH);
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int LINE_W  = $clog2(LINES);
    localparam int ADDR_W  = $clog2(LINES * MAX_WIDTH);
    localparam int KIDX_W  = 5;
    localparam int KCNT_W  = $clog2(KTAPS);
    localparam int SIDE_W  = $clog2(KSIDE);
    localparam int COEF_W  = 18;
    localparam int POS_W   = SIZE_W + 1;
    localparam int PROD_W  = COEF_W + 9;
    localparam int ACC_W   = 32;
    localparam int LIN_W   = ROW_W + SIZE_W + 1;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_PIXEL = 2'd1,
        OP_FLUSH = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_RADIUS = 2'd0,
        REG_WIDTH  = 2'd1,
        REG_HEIGHT = 2'd2
    } reg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CENTER,
        S_TAPS,
        S_FLUSH1,
        S_FLUSH2,
        S_LOAD
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue_center;
        logic issue_tap;
        logic load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic emit_now;
        logic radius_zero;
        logic last_tap;
        logic out_free;
    } status_t;

endpackage

[hdl/rwc_ctrl.sv]
`timescale 1ns / 1ps

module rwc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  rwc_pkg::status_t status,
    output rwc_pkg::cmd_t    cmd,
    output rwc_pkg::state_t  state
);
    import rwc_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && status.emit_now)
                begin
                    state_next = S_CENTER;
                end
            end
            S_CENTER:
            begin
                state_next = status.radius_zero ? S_FLUSH1 : S_TAPS;
            end
            S_TAPS:
            begin
                if (status.last_tap)
                begin
                    state_next = S_FLUSH1;
                end
            end
            S_FLUSH1:
            begin
                state_next = S_FLUSH2;
            end
            S_FLUSH2:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                if (status.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        in_stall         = (state_reg != S_IDLE);
        cmd.accept       = (state_reg == S_IDLE) && in_valid;
        cmd.issue_center = (state_reg == S_CENTER);
        cmd.issue_tap    = (state_reg == S_TAPS);
        cmd.load         = (state_reg == S_LOAD) && status.out_free;
    end

    assign state = state_reg;

endmodule

[hdl/rwc_datapath.sv]
`timescale 1ns / 1ps

module rwc_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [rwc_pkg::SIZE_W-1:0]          cfg_data,
    input  logic [1:0]                          operation,
    input  logic [rwc_pkg::KIDX_W-1:0]          coeff_index,
    input  logic signed [rwc_pkg::COEF_W-1:0]   coeff_value,
    input  logic [7:0]                          pixel_red,
    input  logic [7:0]                          pixel_green,
    input  logic [7:0]                          pixel_blue,
    input  logic [7:0]                          pixel_alpha,
    input  rwc_pkg::cmd_t                       cmd,
    output rwc_pkg::status_t                    status,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic [7:0]                          out_alpha,
    output logic                                frame_last
);
    import rwc_pkg::*;

    // Configuration registers.
    logic [RAD_W-1:0]  radius_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;

    // Frame counters.
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [COL_W-1:0]  in_col_reg, in_col_next;
    logic [LINE_W-1:0] in_line_reg, in_line_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic [COL_W-1:0]  out_col_reg, out_col_next;
    logic [LINE_W-1:0] out_line_reg, out_line_next;
    logic              draining_reg, draining_next;

    // Work item and window iterators.
    logic [COL_W-1:0]  work_col_reg;
    logic [LINE_W-1:0] work_line_reg;
    logic              work_last_reg;
    logic [SIDE_W-1:0] a_reg;
    logic [SIDE_W-1:0] b_reg;
    logic [KCNT_W-1:0] k_reg;
    logic [LINE_W-1:0] line_it_reg;
    logic signed [POS_W-1:0] rr_reg;
    logic signed [POS_W-1:0] cc_reg;
    logic signed [POS_W-1:0] cc_base_reg;

    // Storage.
    logic signed [COEF_W-1:0] kernel_mem [KTAPS];
    logic [31:0]              row_mem [LINES * MAX_WIDTH];

    // Pipeline.
    logic [31:0]              rd_data_reg;
    logic signed [COEF_W-1:0] p1_weight_reg;
    logic                     p1_tap_reg;
    logic                     p1_center_reg;
    logic signed [PROD_W-1:0] prod_r_reg, prod_g_reg, prod_b_reg;
    logic                     p2_tap_reg;
    logic [31:0]              center_reg;
    logic signed [ACC_W-1:0]  acc_r_reg, acc_g_reg, acc_b_reg;

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_red_reg, out_green_reg, out_blue_reg, out_alpha_reg;
    logic       frame_last_reg;

    logic [RAD_W-1:0]  r_eff;
    logic [SIZE_W-1:0] w_eff;
    logic [SIZE_W-1:0] h_eff;
    logic [SIDE_W-1:0] side_last;
    logic [LIN_W-1:0]  pos_lin;
    logic [LIN_W-1:0]  lag_lin;
    logic              pos_ge_lag;
    logic              in_col_end, in_row_end, in_wrap;
    logic              out_col_end, out_row_end, out_wrap;
    logic              op_pixel, op_flush;
    logic              emit_now;
    logic              pixel_write;
    logic              tap_in_frame;
    logic [ADDR_W-1:0] rd_addr;
    logic [LINE_W:0]   start_line_wide;
    logic              out_taken;

    // Effective register values.
    always_comb
    begin
        r_eff = (radius_reg > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : radius_reg;
        if (width_reg == '0)
        begin
            w_eff = SIZE_W'(1);
        end
        else if (width_reg > SIZE_W'(MAX_WIDTH))
        begin
            w_eff = SIZE_W'(MAX_WIDTH);
        end
        else
        begin
            w_eff = width_reg;
        end
        if (height_reg == '0)
        begin
            h_eff = SIZE_W'(1);
        end
        else if (height_reg > SIZE_W'(MAX_HEIGHT))
        begin
            h_eff = SIZE_W'(MAX_HEIGHT);
        end
        else
        begin
            h_eff = height_reg;
        end
        side_last = SIDE_W'({r_eff, 1'b0});
    end

    // Item decode and position checks.
    always_comb
    begin
        op_pixel    = (op_t'(operation) == OP_PIXEL);
        op_flush    = (op_t'(operation) == OP_FLUSH);
        pos_lin     = LIN_W'(in_row_reg * w_eff) + LIN_W'(in_col_reg);
        lag_lin     = LIN_W'(r_eff * w_eff) + LIN_W'(r_eff);
        pos_ge_lag  = (pos_lin >= lag_lin);
        in_col_end  = (SIZE_W'(in_col_reg) + SIZE_W'(1) >= w_eff);
        in_row_end  = (SIZE_W'(in_row_reg) + SIZE_W'(1) >= h_eff);
        in_wrap     = in_col_end && in_row_end;
        out_col_end = (SIZE_W'(out_col_reg) + SIZE_W'(1) >= w_eff);
        out_row_end = (SIZE_W'(out_row_reg) + SIZE_W'(1) >= h_eff);
        out_wrap    = out_col_end && out_row_end;
        emit_now    = (op_pixel || op_flush) &&
                      (draining_reg || (op_pixel && pos_ge_lag));
        pixel_write = cmd.accept && op_pixel && !draining_reg;
        start_line_wide = (out_line_reg >= LINE_W'(r_eff)) ?
                          {1'b0, out_line_reg} - (LINE_W + 1)'(r_eff) :
                          {1'b0, out_line_reg} + (LINE_W + 1)'(LINES) -
                          (LINE_W + 1)'(r_eff);
    end

    // Counter and drain state updates.
    always_comb
    begin
        in_row_next   = in_row_reg;
        in_col_next   = in_col_reg;
        in_line_next  = in_line_reg;
        out_row_next  = out_row_reg;
        out_col_next  = out_col_reg;
        out_line_next = out_line_reg;
        draining_next = draining_reg;
        if (cmd.accept && emit_now)
        begin
            if (out_col_end)
            begin
                out_col_next = '0;
                if (out_row_end)
                begin
                    out_row_next  = '0;
                    out_line_next = '0;
                end
                else
                begin
                    out_row_next  = out_row_reg + ROW_W'(1);
                    out_line_next = (out_line_reg == LINE_W'(LINES - 1)) ?
                                    '0 : out_line_reg + LINE_W'(1);
                end
            end
            else
            begin
                out_col_next = out_col_reg + COL_W'(1);
            end
            if (draining_reg && out_wrap)
            begin
                draining_next = 1'b0;
            end
        end
        if (pixel_write)
        begin
            if (in_col_end)
            begin
                in_col_next = '0;
                if (in_row_end)
                begin
                    in_row_next  = '0;
                    in_line_next = '0;
                end
                else
                begin
                    in_row_next  = in_row_reg + ROW_W'(1);
                    in_line_next = (in_line_reg == LINE_W'(LINES - 1)) ?
                                   '0 : in_line_reg + LINE_W'(1);
                end
            end
            else
            begin
                in_col_next = in_col_reg + COL_W'(1);
            end
            if (in_wrap && !(emit_now && out_wrap))
            begin
                draining_next = 1'b1;
            end
        end
    end

    // Configuration, counters and output control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg    <= '0;
            width_reg     <= SIZE_W'(1);
            height_reg    <= SIZE_W'(1);
            in_row_reg    <= '0;
            in_col_reg    <= '0;
            in_line_reg   <= '0;
            out_row_reg   <= '0;
            out_col_reg   <= '0;
            out_line_reg  <= '0;
            draining_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            p1_tap_reg    <= 1'b0;
            p1_center_reg <= 1'b0;
            p2_tap_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    REG_RADIUS: radius_reg <= cfg_data[RAD_W-1:0];
                    REG_WIDTH:  width_reg  <= cfg_data;
                    REG_HEIGHT: height_reg <= cfg_data;
                    default:    ;
                endcase
            end
            in_row_reg    <= in_row_next;
            in_col_reg    <= in_col_next;
            in_line_reg   <= in_line_next;
            out_row_reg   <= out_row_next;
            out_col_reg   <= out_col_next;
            out_line_reg  <= out_line_next;
            draining_reg  <= draining_next;
            p1_tap_reg    <= cmd.issue_tap && tap_in_frame;
            p1_center_reg <= cmd.issue_center;
            p2_tap_reg    <= p1_tap_reg;
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_taken)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_taken = out_valid_reg && !out_stall;

    // Kernel weight store.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && (op_t'(operation) == OP_LOAD) &&
            (coeff_index < KIDX_W'(KTAPS)))
        begin
            kernel_mem[KCNT_W'(coeff_index)] <= coeff_value;
        end
    end

    // Tap position check and read address.
    always_comb
    begin
        tap_in_frame = !rr_reg[POS_W-1] && !cc_reg[POS_W-1] &&
                       (rr_reg[SIZE_W-1:0] < h_eff) &&
                       (cc_reg[SIZE_W-1:0] < w_eff);
        if (cmd.issue_center)
        begin
            rd_addr = {work_line_reg, work_col_reg};
        end
        else
        begin
            rd_addr = {line_it_reg, cc_reg[COL_W-1:0]};
        end
    end

    // Line store: pixel write and registered read.
    always_ff @(posedge clk)
    begin
        if (pixel_write)
        begin
            row_mem[{in_line_reg, in_col_reg}] <=
                {pixel_alpha, pixel_blue, pixel_green, pixel_red};
        end
        if (cmd.issue_center || cmd.issue_tap)
        begin
            rd_data_reg <= row_mem[rd_addr];
        end
    end

    // Work capture, window walk and multiply-accumulate.
    always_ff @(posedge clk)
    begin
        if (cmd.accept && emit_now)
        begin
            work_col_reg  <= out_col_reg;
            work_line_reg <= out_line_reg;
            work_last_reg <= out_wrap;
            a_reg         <= '0;
            b_reg         <= '0;
            k_reg         <= '0;
            line_it_reg   <= start_line_wide[LINE_W-1:0];
            rr_reg        <= POS_W'(out_row_reg) - POS_W'(r_eff);
            cc_reg        <= POS_W'(out_col_reg) - POS_W'(r_eff);
            cc_base_reg   <= POS_W'(out_col_reg) - POS_W'(r_eff);
            acc_r_reg     <= '0;
            acc_g_reg     <= '0;
            acc_b_reg     <= '0;
        end
        else
        begin
            if (cmd.issue_tap)
            begin
                k_reg <= k_reg + KCNT_W'(1);
                if (b_reg == side_last)
                begin
                    b_reg       <= '0;
                    a_reg       <= a_reg + SIDE_W'(1);
                    rr_reg      <= rr_reg + POS_W'(1);
                    cc_reg      <= cc_base_reg;
                    line_it_reg <= (line_it_reg == LINE_W'(LINES - 1)) ?
                                   '0 : line_it_reg + LINE_W'(1);
                end
                else
                begin
                    b_reg  <= b_reg + SIDE_W'(1);
                    cc_reg <= cc_reg + POS_W'(1);
                end
            end
            if (p2_tap_reg)
            begin
                acc_r_reg <= acc_r_reg + ACC_W'(prod_r_reg);
                acc_g_reg <= acc_g_reg + ACC_W'(prod_g_reg);
                acc_b_reg <= acc_b_reg + ACC_W'(prod_b_reg);
            end
        end
        if (cmd.issue_tap)
        begin
            p1_weight_reg <= kernel_mem[k_reg];
        end
        prod_r_reg <= $signed({1'b0, rd_data_reg[7:0]}) * p1_weight_reg;
        prod_g_reg <= $signed({1'b0, rd_data_reg[15:8]}) * p1_weight_reg;
        prod_b_reg <= $signed({1'b0, rd_data_reg[23:16]}) * p1_weight_reg;
        if (p1_center_reg)
        begin
            center_reg <= rd_data_reg;
        end
    end

    // Clamp a channel sum to 0..255 after dropping the fraction bits.
    function automatic logic [7:0] clamp_channel(input logic signed [ACC_W-1:0] s);
        logic [7:0] v;
        if (s[ACC_W-1])
        begin
            v = 8'd0;
        end
        else if (|s[ACC_W-2:COEF_FRAC_BITS+8])
        begin
            v = 8'hFF;
        end
        else
        begin
            v = s[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
        end
        return v;
    endfunction

    // Output register load.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            if (r_eff == '0)
            begin
                out_red_reg   <= center_reg[7:0];
                out_green_reg <= center_reg[15:8];
                out_blue_reg  <= center_reg[23:16];
            end
            else
            begin
                out_red_reg   <= clamp_channel(acc_r_reg);
                out_green_reg <= clamp_channel(acc_g_reg);
                out_blue_reg  <= clamp_channel(acc_b_reg);
            end
            out_alpha_reg  <= center_reg[31:24];
            frame_last_reg <= work_last_reg;
        end
    end

    always_comb
    begin
        status.emit_now    = emit_now;
        status.radius_zero = (r_eff == '0);
        status.last_tap    = (a_reg == side_last) && (b_reg == side_last);
        status.out_free    = !out_valid_reg || !out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign out_alpha  = out_alpha_reg;
    assign frame_last = frame_last_reg;

endmodule

[hdl/rgb_window_convolution.sv]
`timescale 1ns / 1ps
// Channel   Handshake             Payload
// config    cfg_write             cfg_index, cfg_data
// input     in_valid / in_stall   operation, coeff_*, pixel_*
// output    out_valid / out_stall out_red/green/blue/alpha, frame_last
//
// Coefficient loads, idle flushes and pixels that produce no result keep the block idle.
// A pixel or flush that produces a result passes the center, tap (none at radius 0),
// flush1, flush2 and load states: one line store read per window tap sets the pace.
// The result waits in an output register while the next item is taken.
// While that register is full and stalled, the block holds in its load state.
// Reset (rst_n low, asynchronous) clears counters, drain state, config and valid bits.
// Kernel weights and the line store hold no reset value.

module rgb_window_convolution (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [1:0]                          cfg_index,
    input  logic [rwc_pkg::SIZE_W-1:0]          cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [1:0]                          operation,
    input  logic [rwc_pkg::KIDX_W-1:0]          coeff_index,
    input  logic signed [rwc_pkg::COEF_W-1:0]   coeff_value,
    input  logic [7:0]                          pixel_red,
    input  logic [7:0]                          pixel_green,
    input  logic [7:0]                          pixel_blue,
    input  logic [7:0]                          pixel_alpha,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic [7:0]                          out_alpha,
    output logic                                frame_last
);
    import rwc_pkg::*;

    cmd_t    cmd;
    status_t status;
    state_t  state;

    rwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd),
        .state    (state)
    );

    rwc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .operation   (operation),
        .coeff_index (coeff_index),
        .coeff_value (coeff_value),
        .pixel_red   (pixel_red),
        .pixel_green (pixel_green),
        .pixel_blue  (pixel_blue),
        .pixel_alpha (pixel_alpha),
        .cmd         (cmd),
        .status      (status),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .frame_last  (frame_last)
    );

`ifndef NO_ASSERTIONS
    // A new result appears only from the load state.
    a_load_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state == S_LOAD))
        else $error("result appeared outside the load state");

    // The tap walk never runs at radius zero.
    a_taps_radius: assert property (@(posedge clk) disable iff (!rst_n)
        (state == S_TAPS) |-> !status.radius_zero)
        else $error("tap walk at radius zero");

    // After a transfer, a following result must come from a fresh load.
    a_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall) |=> (!out_valid || state == S_IDLE))
        else $error("result held past its transfer");
`endif

endmodule
